[rtl/crrc_pkg.sv]
package crrc_pkg;

  typedef logic [22:0] offset_t;

  typedef enum logic [1:0] {
    REQ_RESERVE = 2'd0,
    REQ_COMMIT  = 2'd1,
    REQ_START   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IN_PLACE  = 3'd0,
    ST_BOUNCE    = 3'd1,
    ST_FULL      = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_ALREADY   = 3'd5,
    ST_NOTHING   = 3'd6,
    ST_DONE      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CFG_RING_MIN        = 2'd0,
    CFG_RING_MAX        = 2'd1,
    CFG_RESERVE_CAPABLE = 2'd2
  } cfg_index_e;

  localparam offset_t BOUNCE_BYTES   = 23'd1048576;
  localparam offset_t RING_MIN_RESET = 23'd1024;
  localparam offset_t RING_MAX_RESET = 23'd4194304;
  localparam offset_t SMALL_BYTES    = 23'd4;

  typedef struct packed {
    offset_t ring_min;
    offset_t ring_max;
    logic    reserve_capable;
  } cfg_t;

  typedef struct packed {
    offset_t wr_ptr;
    offset_t reserved_size;
    logic    bounce_in_use;
  } ring_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    offset_t    byte_count;
    offset_t    stop_offset;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    offset_t    write_offset;
    offset_t    first_chunk;
    offset_t    ptr_after;
    offset_t    reserved_mark;
  } result_t;

endpackage

[rtl/command_ring_reserve_commit_unit.sv]
// Producer side of a circular command ring between byte offsets ring_min and
// ring_max. Each request item (reserve, commit or start) arrives on the
// req_valid/req_ready channel and yields exactly one result item on the
// rsp_valid/rsp_ready channel: a status, the pointer before and after the
// request, the bounced first-chunk length and the reserved mark.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, the block itself does not enforce this.
// A request passes two registers, the input register and the result register.
// Throughput: one item per cycle while rsp_ready allows, set by the single
// pass of step logic between the input register and the result register,
// which also updates the pointer and reservation state.
// Reset: ring_min 1024, ring_max 4194304, reserve_capable 0, pointer 1024,
// no reservation, both registers empty.
// Stall: while rsp_ready is low the result register holds; one more item
// waits in the input register and req_ready then drops until the result is
// taken.
module command_ring_reserve_commit_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  crrc_pkg::offset_t     cfg_data,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            req_type,
  input  crrc_pkg::offset_t     byte_count,
  input  crrc_pkg::offset_t     stop_offset,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [2:0]            status,
  output crrc_pkg::offset_t     write_offset,
  output crrc_pkg::offset_t     first_chunk,
  output crrc_pkg::offset_t     ptr_after,
  output crrc_pkg::offset_t     reserved_mark
);
  import crrc_pkg::*;

  cfg_t        cfg;
  ring_state_t cur;
  ring_state_t nxt;
  item_t       item_q;
  logic        item_valid;
  result_t     res;
  result_t     res_q;
  logic        advance;

  assign advance   = item_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_min        <= RING_MIN_RESET;
      cfg.ring_max        <= RING_MAX_RESET;
      cfg.reserve_capable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index_e'(cfg_index))
        CFG_RING_MIN:        cfg.ring_min        <= cfg_data;
        CFG_RING_MAX:        cfg.ring_max        <= cfg_data;
        CFG_RESERVE_CAPABLE: cfg.reserve_capable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ready) begin
      item_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      item_q.req_type    <= req_type;
      item_q.byte_count  <= byte_count;
      item_q.stop_offset <= stop_offset;
    end
  end

  crrc_step u_step (
    .cfg  (cfg),
    .cur  (cur),
    .item (item_q),
    .nxt  (nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.wr_ptr        <= RING_MIN_RESET;
      cur.reserved_size <= '0;
      cur.bounce_in_use <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (advance) begin
        cur       <= nxt;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign status        = res_q.status;
  assign write_offset  = res_q.write_offset;
  assign first_chunk   = res_q.first_chunk;
  assign ptr_after     = res_q.ptr_after;
  assign reserved_mark = res_q.reserved_mark;

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> item_valid && rsp_valid && !rsp_ready)
    else $error("req_ready low without a stalled result");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced item did not reach the result register");

  a_error_keeps_pointer: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL || status == ST_TOO_LARGE ||
                  status == ST_MISALIGNED || status == ST_ALREADY ||
                  status == ST_NOTHING) |-> ptr_after == write_offset)
    else $error("error or full result moved the pointer");

  a_start_rewinds: assert property (@(posedge clk) disable iff (rst)
    advance && item_q.req_type == REQ_START |=>
      ptr_after == $past(cfg.ring_min) && cur.reserved_size == '0)
    else $error("start did not rewind the pointer");

endmodule

[rtl/crrc_step.sv]
module crrc_step (
  input  crrc_pkg::cfg_t        cfg,
  input  crrc_pkg::ring_state_t cur,
  input  crrc_pkg::item_t       item,
  output crrc_pkg::ring_state_t nxt,
  output crrc_pkg::result_t     res
);
  import crrc_pkg::*;

  offset_t            span;
  offset_t            nc;
  offset_t            nb;
  offset_t            stop;
  offset_t            tail;
  logic [23:0]        sum;
  logic [23:0]        wrapped;
  logic signed [24:0] room;
  logic               room_short;

  assign nc   = cur.wr_ptr;
  assign nb   = item.byte_count;
  assign stop = item.stop_offset;
  assign span = (cfg.ring_max > cfg.ring_min) ? (cfg.ring_max - cfg.ring_min) : '0;
  assign tail = (cfg.ring_max > nc) ? (cfg.ring_max - nc) : '0;
  assign sum  = {1'b0, nc} + {1'b0, nb};
  assign wrapped = (sum >= {1'b0, cfg.ring_max}) ? (sum - {1'b0, span}) : sum;
  assign room = $signed({2'b00, cfg.ring_max}) - $signed({2'b00, nc})
              + $signed({2'b00, stop}) - $signed({2'b00, cfg.ring_min});
  assign room_short = room <= $signed({2'b00, nb});

  always_comb begin
    logic fit;
    logic full;
    fit  = 1'b0;
    full = 1'b0;
    nxt  = cur;
    res.status        = ST_DONE;
    res.write_offset  = nc;
    res.first_chunk   = '0;
    res.reserved_mark = '0;
    case (req_e'(item.req_type))
      REQ_RESERVE: begin
        if (nb > BOUNCE_BYTES || nb > span) begin
          res.status = ST_TOO_LARGE;
        end else if (nb[1:0] != 2'b00) begin
          res.status = ST_MISALIGNED;
        end else if (cur.reserved_size != '0) begin
          res.status = ST_ALREADY;
        end else begin
          if (nc >= stop) begin
            if (sum < {1'b0, cfg.ring_max} ||
                (sum == {1'b0, cfg.ring_max} && stop > cfg.ring_min)) begin
              fit = 1'b1;
            end else if (room_short) begin
              full = 1'b1;
            end
          end else if (sum < {1'b0, stop}) begin
            fit = 1'b1;
          end else begin
            full = 1'b1;
          end
          if (full) begin
            res.status = ST_FULL;
          end else if (fit && (cfg.reserve_capable || nb <= SMALL_BYTES)) begin
            res.status        = ST_IN_PLACE;
            nxt.bounce_in_use = 1'b0;
            nxt.reserved_size = nb;
            res.reserved_mark = cfg.reserve_capable ? nb : '0;
          end else begin
            res.status        = ST_BOUNCE;
            nxt.bounce_in_use = 1'b1;
            nxt.reserved_size = nb;
          end
        end
      end
      REQ_COMMIT: begin
        if (cur.reserved_size == '0) begin
          res.status = ST_NOTHING;
        end else if (nb[1:0] != 2'b00) begin
          res.status = ST_MISALIGNED;
        end else if (nb > cur.reserved_size) begin
          res.status = ST_TOO_LARGE;
        end else begin
          nxt.reserved_size = '0;
          if (cur.bounce_in_use) begin
            res.first_chunk = (nb < tail) ? nb : tail;
            if (cfg.reserve_capable) begin
              res.reserved_mark = nb;
            end
          end
          nxt.wr_ptr = wrapped[22:0];
        end
      end
      REQ_START: begin
        nxt.wr_ptr        = cfg.ring_min;
        nxt.reserved_size = '0;
        nxt.bounce_in_use = 1'b0;
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.ptr_after = nxt.wr_ptr;
  end

endmodule
